// ----- rtl/core/rcdc_pkg.sv -----
// Shared types, constants and fingerprint table functions for the content-defined chunker.
package rcdc_pkg;

    // Fingerprint arithmetic over GF(2) modulo the fixed 64-bit polynomial.
    localparam int unsigned PRINT_W   = 63;
    localparam logic [63:0] POLY_VALUE = 64'hbfe6b8a5bf378d83;
    localparam logic [63:0] TOP_BIT    = 64'h8000000000000000;

    // Configuration register indexes.
    localparam logic [7:0] REG_MIN_LEN    = 8'd0;
    localparam logic [7:0] REG_MAX_LEN    = 8'd1;
    localparam logic [7:0] REG_MASK_BITS  = 8'd2;
    localparam logic [7:0] REG_BREAK_MARK = 8'd3;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_MIN_LEN    = 16'd2048;
    localparam logic [15:0] RST_MAX_LEN    = 16'd65535;
    localparam logic [4:0]  RST_MASK_BITS  = 5'd12;
    localparam logic [15:0] RST_BREAK_MARK = 16'h0078;

    // Widest comparison of fingerprint bits against the mark.
    localparam logic [4:0] MASK_BITS_MAX = 5'd16;

    // Break causes.
    localparam logic [1:0] CAUSE_CONTENT = 2'd0;
    localparam logic [1:0] CAUSE_MAX_LEN = 2'd1;
    localparam logic [1:0] CAUSE_END_BUF = 2'd2;

    // Read, write and clear controls of the window store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } t_win_ctrl;

    // Carry-less product of x and y reduced modulo the polynomial.
    function automatic logic [63:0] gf_mulmod(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] r;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = r << 1;
            if (r[63]) begin
                r = r ^ POLY_VALUE;
            end
            if (x[b]) begin
                r = r ^ y;
            end
        end
        return r;
    endfunction

    // Contribution of one bit of the departing top byte to the modular shift.
    function automatic logic [PRINT_W-1:0] append_entry(input int unsigned k);
        logic [63:0] r;
        r = gf_mulmod(64'd1 << k, POLY_VALUE ^ TOP_BIT);
        return r[PRINT_W-1:0];
    endfunction

    localparam logic [PRINT_W-1:0] APPEND_BASIS [8] = '{
        append_entry(0), append_entry(1), append_entry(2), append_entry(3),
        append_entry(4), append_entry(5), append_entry(6), append_entry(7)
    };

    // The append table is linear in its index, so it reduces to an XOR network.
    function automatic logic [PRINT_W-1:0] append_xor(input logic [7:0] idx);
        logic [PRINT_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < 8; k++) begin
            if (idx[k]) begin
                acc = acc ^ APPEND_BASIS[k];
            end
        end
        return acc;
    endfunction

    // Shift one byte into the fingerprint and reduce.
    function automatic logic [PRINT_W-1:0] shift_in(input logic [PRINT_W-1:0] p,
                                                    input logic [7:0] m);
        return {p[PRINT_W-9:0], m} ^ append_xor(p[PRINT_W-1:PRINT_W-8]);
    endfunction

    // Contribution of one bit of the byte leaving a window of w bytes.
    function automatic logic [PRINT_W-1:0] remove_entry(input int unsigned w,
                                                        input int unsigned k);
        logic [PRINT_W-1:0] s;
        logic [63:0]        r;
        s = {{(PRINT_W-1){1'b0}}, 1'b1};
        for (int unsigned j = 1; j < w; j++) begin
            s = shift_in(s, 8'd0);
        end
        r = gf_mulmod(64'd1 << k, {1'b0, s});
        return r[PRINT_W-1:0];
    endfunction

endpackage

// ----- rtl/core/rcdc_window.sv -----
// Sliding window store: synchronous byte memory with per-entry valid bits.
module rcdc_window #(
    parameter int WINDOW_BYTES = 48
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rcdc_pkg::t_win_ctrl             i_ctrl,
    input  logic [$clog2(WINDOW_BYTES)-1:0] i_addr,
    input  logic [7:0]                      i_wr_data,
    output logic [7:0]                      o_old_byte
);
    import rcdc_pkg::*;

    localparam int AW = $clog2(WINDOW_BYTES);

    logic [7:0]              r_mem [WINDOW_BYTES];
    logic [7:0]              r_rd_data;
    logic [AW-1:0]           r_addr;
    logic [WINDOW_BYTES-1:0] r_valid;

    // The slot read for an item is the slot that item later writes; the read address is held for the write.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[r_addr] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_addr <= i_addr;
        end
    end

    // A cleared window reads as zero until each slot is written again.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_valid <= '0;
        end else if (i_ctrl.wr_en) begin
            r_valid[r_addr] <= 1'b1;
        end
    end

    assign o_old_byte = r_valid[r_addr] ? r_rd_data : 8'd0;

endmodule

// ----- rtl/core/rabin_content_defined_chunker.sv -----
// Content-defined chunker: rolling Rabin fingerprint over a byte window, break detection.
// A break passes the update stage and then the output register before it is offered
// on the master side, and a stalling sink can hold it in either.
// Throughput: one byte per cycle, set by the fingerprint feedback register and the
// window memory's single read and write port; the sink stalling holds the pipeline.
// Reset: synchronous, active low; clears the window valid bits, the fingerprint, the
// counters and the configuration registers to their defaults, with no clearing pass.
module rabin_content_defined_chunker #(
    parameter int WINDOW_BYTES = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte stream in.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // end_of_buffer
    // Break records out.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [31:0] break_position, [47:32] chunk_length
    output logic [1:0]  o_m_tuser,   // [1:0] break_cause
    output logic        o_m_tlast,   // last_of_buffer
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import rcdc_pkg::*;

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_BYTES - 1);

    // Removal of the departing byte is linear in that byte, so the table becomes
    // eight constant words selected by its bits and folded by XOR.
    localparam logic [PRINT_W-1:0] REMOVE_BASIS [8] = '{
        remove_entry(WINDOW_BYTES, 0), remove_entry(WINDOW_BYTES, 1),
        remove_entry(WINDOW_BYTES, 2), remove_entry(WINDOW_BYTES, 3),
        remove_entry(WINDOW_BYTES, 4), remove_entry(WINDOW_BYTES, 5),
        remove_entry(WINDOW_BYTES, 6), remove_entry(WINDOW_BYTES, 7)
    };

    // Configuration registers.
    logic [15:0] r_min_len;
    logic [15:0] r_max_len;
    logic [4:0]  r_mask_bits;
    logic [15:0] r_break_mark;

    // Front stage: next window slot, issued to the memory read on acceptance.
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] n_ptr;

    // Update stage: the accepted byte waits here while its old window byte is read.
    logic          r_s1_valid;
    logic [7:0]    r_s1_byte;
    logic          r_s1_last;

    // Running state of the chunk being built.
    logic [PRINT_W-1:0] r_print;
    logic [15:0]        r_cur_len;
    logic [31:0]        r_offset;

    // Output register.
    logic        r_out_valid;
    logic [31:0] r_out_pos;
    logic [15:0] r_out_len;
    logic [1:0]  r_out_cause;
    logic        r_out_last;

    logic               s_in_accept;
    logic               s_advance;
    t_win_ctrl          s_win_ctrl;
    logic [7:0]         s_old_byte;
    logic [PRINT_W-1:0] s_remove;
    logic [PRINT_W-1:0] n_print;
    logic [15:0]        s_len;
    logic [4:0]         s_mask_w;
    logic [15:0]        s_mask;
    logic               s_match;
    logic               s_max_hit;
    logic               s_break;
    logic [1:0]         s_cause;

    // Configuration writes are always taken; indexes beyond the list are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len    <= RST_MIN_LEN;
            r_max_len    <= RST_MAX_LEN;
            r_mask_bits  <= RST_MASK_BITS;
            r_break_mark <= RST_BREAK_MARK;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MIN_LEN:    r_min_len    <= i_cfg_data;
                REG_MAX_LEN:    r_max_len    <= i_cfg_data;
                REG_MASK_BITS:  r_mask_bits  <= i_cfg_data[4:0];
                REG_BREAK_MARK: r_break_mark <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The update stage moves on when the output register is free or being emptied,
    // and a new byte enters whenever the update stage is empty or moving on.
    assign s_advance   = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_s1_valid || s_advance;
    assign s_in_accept = i_s_tvalid && o_s_tready;

    // The window pointer runs ahead of the fingerprint; the end of a buffer is known
    // on acceptance, so the pointer restarts at slot zero without waiting.
    always_comb begin
        if (i_s_tlast) begin
            n_ptr = '0;
        end else if (r_ptr == LAST_SLOT) begin
            n_ptr = '0;
        end else begin
            n_ptr = r_ptr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (s_in_accept) begin
            r_ptr <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_accept) begin
            r_s1_byte <= i_s_tdata;
            r_s1_last <= i_s_tlast;
        end
    end

    // A break clears the whole window, the new byte included, so it is not written.
    assign s_win_ctrl.rd_en = s_in_accept;
    assign s_win_ctrl.wr_en = s_advance && !s_break;
    assign s_win_ctrl.clear = s_advance && s_break;

    rcdc_window #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (s_win_ctrl),
        .i_addr     (r_ptr),
        .i_wr_data  (r_s1_byte),
        .o_old_byte (s_old_byte)
    );

    // Fingerprint update: remove the departing byte, then shift the new one in.
    always_comb begin
        s_remove = '0;
        for (int k = 0; k < 8; k++) begin
            if (s_old_byte[k]) begin
                s_remove = s_remove ^ REMOVE_BASIS[k];
            end
        end
        n_print = shift_in(r_print ^ s_remove, r_s1_byte);
    end

    // Mask widths above sixteen compare sixteen bits; the mark itself is not masked,
    // so a mark with bits above the mask never matches.
    assign s_mask_w = (r_mask_bits > MASK_BITS_MAX) ? MASK_BITS_MAX : r_mask_bits;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s_mask[i] = (5'(i) < s_mask_w);
        end
    end

    assign s_len     = r_cur_len + 16'd1;
    assign s_match   = ((n_print[15:0] & s_mask) == r_break_mark) && (s_len >= r_min_len);
    assign s_max_hit = s_len >= r_max_len;
    assign s_break   = s_match || s_max_hit || r_s1_last;

    always_comb begin
        priority if (s_match) begin
            s_cause = CAUSE_CONTENT;
        end else if (s_max_hit) begin
            s_cause = CAUSE_MAX_LEN;
        end else begin
            s_cause = CAUSE_END_BUF;
        end
    end

    // After any break the fingerprint and the length restart; at the end of a
    // buffer the offset restarts as well.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_print   <= '0;
            r_cur_len <= '0;
            r_offset  <= '0;
        end else if (s_advance) begin
            r_print   <= s_break ? '0 : n_print;
            r_cur_len <= s_break ? 16'd0 : s_len;
            r_offset  <= r_s1_last ? 32'd0 : r_offset + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_advance) begin
            r_out_valid <= s_break;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_advance && s_break) begin
            r_out_pos   <= r_offset;
            r_out_len   <= s_len;
            r_out_cause <= s_cause;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_len, r_out_pos};
    assign o_m_tuser  = r_out_cause;
    assign o_m_tlast  = r_out_last;

endmodule

// ----- tb/tb_rabin_content_defined_chunker.sv -----
// Self-checking testbench for the Rabin fingerprint content-defined chunker.
`timescale 1ns / 100ps

module tb_rabin_content_defined_chunker;
    import rcdc_pkg::*;

    // The window depth is kept the same in the block and in the local prediction.
    localparam int          WIN         = 48;
    // The fingerprint polynomial, with its top bit.
    localparam logic [63:0] FP_POLY     = 64'hbfe6b8a5bf378d83;
    localparam logic [63:0] FP_TOP      = 64'h8000000000000000;
    // An index that names no register, so a write to it must change nothing.
    localparam logic [7:0]  REG_NONE    = 8'hFF;
    // Time allowed for the pipeline to settle once a test has drained.
    localparam int          SETTLE      = 6;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 300;

    // One byte of the input stream together with its end-of-buffer flag.
    typedef struct packed {
        logic [7:0] data;
        logic       eob;
    } t_in_byte;

    // One break record as the block should report it.
    typedef struct packed {
        logic [31:0] pos;
        logic [15:0] len;
        logic [1:0]  cause;
        logic        last;
    } t_break_rec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;    // [7:0] data_byte
    logic        i_s_tlast = 1'b0;  // end_of_buffer
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;         // [31:0] break_position, [47:32] chunk_length
    logic [1:0]  o_m_tuser;         // [1:0] break_cause
    logic        o_m_tlast;         // last_of_buffer
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    rabin_content_defined_chunker #(
        .WINDOW_BYTES(WIN)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Bytes still to be offered, and breaks predicted but not yet seen.
    t_in_byte    feed_bytes[$];
    t_break_rec  due_breaks[$];
    t_in_byte    next_byte;
    logic        s_taken = 1'b0;

    // Idle percentages of the two sides and the long sink hold-off.
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    logic        sink_hold = 1'b0;
    logic        hold_start = 1'b0;

    int unsigned err_count = 0;
    int unsigned cycle_count = 0;

    // Shadow of the configuration registers.
    logic [15:0] cfg_min;
    logic [15:0] cfg_max;
    logic [4:0]  cfg_mask_bits;
    logic [15:0] cfg_mark;

    // Shadow of the chunker state: fingerprint, window, and stream counters.
    logic [62:0] fp;
    logic [7:0]  win_mem[WIN];
    int unsigned win_ptr;
    logic [31:0] byte_pos;
    logic [15:0] chunk_len;

    // Fingerprint tables: the append table folds the departing top byte back in,
    // the remove table cancels the byte that drops out of the window.
    logic [62:0] append_tab[256];
    logic [62:0] remove_tab[256];

    // Clock: 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Carry-less product of a and b, reduced modulo the polynomial.
    function automatic logic [63:0] clmul_reduce(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] acc;
        acc = '0;
        for (int i = 63; i >= 0; i--) begin
            acc = acc << 1;
            if (acc[63]) begin
                acc = acc ^ FP_POLY;
            end
            if (a[i]) begin
                acc = acc ^ b;
            end
        end
        return acc;
    endfunction

    // Shift one byte into a print and reduce it with the append table.
    function automatic logic [62:0] slide_byte(input logic [62:0] p, input logic [7:0] m);
        return {p[54:0], m} ^ append_tab[p[62:55]];
    endfunction

    task automatic build_tables();
        logic [63:0] prod;
        logic [62:0] unit;
        for (int j = 0; j < 256; j++) begin
            prod = clmul_reduce(64'(j), FP_POLY ^ FP_TOP);
            append_tab[j] = prod[62:0];
        end
        // The weight of the oldest window position is x to the power 8*(WIN-1).
        unit = 63'd1;
        for (int j = 1; j < WIN; j++) begin
            unit = slide_byte(unit, 8'd0);
        end
        for (int j = 0; j < 256; j++) begin
            prod = clmul_reduce(64'(j), {1'b0, unit});
            remove_tab[j] = prod[62:0];
        end
    endtask

    // Clears the print and the window; clear_stream, used at a buffer end, also resets the pointer and counters.
    task automatic clear_window();
        fp = '0;
        for (int i = 0; i < WIN; i++) begin
            win_mem[i] = 8'd0;
        end
    endtask

    task automatic clear_stream();
        clear_window();
        win_ptr = WIN - 1;
        byte_pos = '0;
        chunk_len = '0;
    endtask

    // Advances the shadow state by one accepted byte and queues the break it causes, if any.
    task automatic predict_chunk_break(input logic [7:0] b, input logic eob);
        logic [7:0]  leaving;
        logic [16:0] run_len;
        logic [4:0]  width;
        logic [16:0] sel;
        logic        hit;
        logic        brk;
        logic [1:0]  why;
        t_break_rec  rec;
        win_ptr = (win_ptr == WIN - 1) ? 0 : win_ptr + 1;
        leaving = win_mem[win_ptr];
        win_mem[win_ptr] = b;
        fp = slide_byte(fp ^ remove_tab[leaving], b);

        run_len = {1'b0, chunk_len} + 17'd1;
        width = (cfg_mask_bits > MASK_BITS_MAX) ? MASK_BITS_MAX : cfg_mask_bits;
        sel = (17'd1 << width) - 17'd1;
        // The mark is compared whole, so mark bits above the mask never match.
        hit = ((fp[15:0] & sel[15:0]) == cfg_mark);

        brk = 1'b1;
        why = CAUSE_CONTENT;
        if (hit && run_len >= {1'b0, cfg_min}) begin
            why = CAUSE_CONTENT;
        end else if (run_len >= {1'b0, cfg_max}) begin
            why = CAUSE_MAX_LEN;
        end else if (eob) begin
            why = CAUSE_END_BUF;
        end else begin
            brk = 1'b0;
        end

        if (brk) begin
            rec.pos = byte_pos;
            rec.len = run_len[15:0];
            rec.cause = why;
            rec.last = eob;
            due_breaks.push_back(rec);
            // The window pointer survives a break; only the contents are wiped.
            clear_window();
            chunk_len = '0;
        end else begin
            chunk_len = run_len[15:0];
        end
        byte_pos = byte_pos + 32'd1;
        if (eob) begin
            clear_stream();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // Compares one break transaction with the oldest prediction.
    task automatic check_chunk_break();
        t_break_rec want;
        if (due_breaks.size() == 0) begin
            report_mismatch("unexpected break, position", o_m_tdata[31:0], 32'd0);
        end else begin
            want = due_breaks.pop_front();
            if (o_m_tdata[31:0] !== want.pos) begin
                report_mismatch("break_position", o_m_tdata[31:0], want.pos);
            end
            if (o_m_tdata[47:32] !== want.len) begin
                report_mismatch("chunk_length", 32'(o_m_tdata[47:32]), 32'(want.len));
            end
            if (o_m_tuser !== want.cause) begin
                report_mismatch("break_cause", 32'(o_m_tuser), 32'(want.cause));
            end
            if (o_m_tlast !== want.last) begin
                report_mismatch("last_of_buffer", 32'(o_m_tlast), 32'(want.last));
            end
        end
    endtask

    // Watchdog: a run that has not ended by now is hung.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_rabin_content_defined_chunker: done, errors");
            $finish;
        end
    end

    // Monitor: outputs are sampled at the rising edge. The output transaction is
    // checked before the input transaction of the same edge is predicted, so a
    // stray break can never be matched against a record queued in the same cycle.
    always @(posedge i_clk) begin
        s_taken <= i_s_tvalid && o_s_tready;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                check_chunk_break();
            end
            if (i_s_tvalid && o_s_tready) begin
                predict_chunk_break(i_s_tdata, i_s_tlast);
            end
        end
    end

    // Byte driver: a byte, once offered, is held until its transaction completes;
    // only then may the sender idle or move on to the next byte.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_s_tvalid || s_taken)) begin
            if (feed_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                next_byte = feed_bytes.pop_front();
                i_s_tdata <= next_byte.data;
                i_s_tlast <= next_byte.eob;
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Break sink: stalls at random, and all the time while the long hold-off runs.
    always @(negedge i_clk) begin
        i_m_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end

    // Long hold-off of the sink, counted here so that the sender keeps offering
    // bytes and the block has to fill up and stall its input side.
    initial begin
        while (!hold_start) begin
            @(negedge i_clk);
        end
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        sink_hold <= 1'b0;
    end

    task automatic push_byte(input logic [7:0] b, input logic eob);
        t_in_byte item;
        item.data = b;
        item.eob = eob;
        feed_bytes.push_back(item);
    endtask

    // Queues whole buffers of random length; now and then a buffer is a run of a
    // single repeated byte, which keeps the window full of identical content.
    task automatic push_buffers(input int unsigned total, input int unsigned longest);
        int unsigned left;
        int unsigned run;
        logic [7:0]  fill;
        logic        same;
        left = total;
        while (left != 0) begin
            run = $urandom_range(longest, 1);
            if (run > left) begin
                run = left;
            end
            same = ($urandom_range(7) == 0);
            fill = 8'($urandom_range(255));
            for (int unsigned k = 0; k < run; k++) begin
                push_byte(same ? fill : 8'($urandom_range(255)), k == run - 1);
            end
            left = left - run;
        end
    endtask

    // Waits until every byte has been taken and every break has arrived, then lets
    // the pipeline settle, since the last byte may be one that causes no break.
    task automatic wait_drained();
        while (feed_bytes.size() != 0 || i_s_tvalid || due_breaks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // One register write transaction; the shadow copy follows once it completes.
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            REG_MIN_LEN: begin
                cfg_min = val;
            end
            REG_MAX_LEN: begin
                cfg_max = val;
            end
            REG_MASK_BITS: begin
                cfg_mask_bits = val[4:0];
            end
            REG_BREAK_MARK: begin
                cfg_mark = val;
            end
            default: begin
            end
        endcase
    endtask

    task automatic set_config(input logic [15:0] min_len, input logic [15:0] max_len,
                              input logic [15:0] mask_val, input logic [15:0] mark);
        write_reg(REG_MIN_LEN, min_len);
        write_reg(REG_MAX_LEN, max_len);
        write_reg(REG_MASK_BITS, mask_val);
        write_reg(REG_BREAK_MARK, mark);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
    endtask

    initial begin
        build_tables();
        cfg_min = RST_MIN_LEN;
        cfg_max = RST_MAX_LEN;
        cfg_mask_bits = RST_MASK_BITS;
        cfg_mark = RST_BREAK_MARK;
        clear_stream();

        // Reset is held at the start and released on a falling edge, away from the sampling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles often, sink idles most of the time.
        set_idling(31, 82);

        // Defaults after reset: short buffers close only at their last byte,
        // including buffers of a single byte at both byte extremes.
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'h80, 1'b1);
        wait_drained();

        // Zero mask width with a zero mark and zero minimum: every byte is a
        // content break, and the last one keeps that cause with the last flag.
        set_config(16'd0, 16'd0, 16'd0, 16'd0);
        push_byte(8'h01, 1'b0);
        push_byte(8'hFE, 1'b0);
        push_byte(8'h7F, 1'b1);
        wait_drained();

        // A mark with bits above the mask never matches, so a maximum of zero
        // breaks every byte instead.
        set_config(16'd0, 16'd0, 16'd0, 16'd1);
        push_byte(8'h33, 1'b0);
        push_byte(8'hCC, 1'b0);
        push_byte(8'h0F, 1'b1);
        wait_drained();

        // Largest minimum blocks content breaks; a maximum of three cuts the
        // buffer, and the remainder closes at the buffer end.
        set_config(16'hFFFF, 16'd3, 16'd1, 16'd0);
        for (int i = 0; i < 7; i++) begin
            push_byte(8'($urandom_range(255)), i == 6);
        end
        wait_drained();

        // Widest mask and the largest mark and maximum; a write to an index that
        // names no register must leave all four alone.
        set_config(16'd1, 16'hFFFF, 16'd16, 16'hFFFF);
        write_reg(REG_NONE, 16'hA5A5);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'hA5, 1'b1);
        wait_drained();

        // Random buffers. Frequent content matches on a narrow mask.
        set_config(16'd16, 16'd300, 16'd4, 16'($urandom_range(15)));
        push_buffers(250, 120);
        wait_drained();

        // Mask written with every bit set, so it saturates at sixteen; chunks run
        // past the window length and mostly close at the buffer end.
        set_config(16'd0, 16'hFFFF, 16'hFFFF, 16'($urandom_range(16'hFFFF)));
        push_buffers(150, 80);
        wait_drained();

        // Now the sender idles most of the time and the sink less often.
        set_idling(82, 31);
        set_config(16'd60, 16'd200, 16'd16, 16'($urandom_range(16'hFFFF)));
        push_buffers(250, 400);
        wait_drained();

        set_config(16'd8, 16'd40, 16'd3, 16'($urandom_range(7)));
        push_buffers(150, 60);
        wait_drained();

        // Neither side idles. Breaks come every few bytes while the sink holds
        // off for a long stretch, which backs the block up to its input.
        set_idling(0, 0);
        set_config(16'd1, 16'd5, 16'd1, 16'd1);
        push_buffers(200, 50);
        hold_start = 1'b1;
        wait_drained();

        set_config(16'd100, 16'hFFFF, 16'd6, 16'($urandom_range(63)));
        push_buffers(250, 300);
        wait_drained();

        if (err_count == 0) begin
            $display("tb_rabin_content_defined_chunker: done, clean");
        end else begin
            $display("tb_rabin_content_defined_chunker: done, errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/rcdc_pkg.sv
rtl/core/rcdc_window.sv
rtl/core/rabin_content_defined_chunker.sv
tb/tb_rabin_content_defined_chunker.sv
